// File: hw/rtl/piecewise_linear_moisture_calibration_macros.svh
// Assertion helpers for the moisture calibration block.
`ifndef PIECEWISE_LINEAR_MOISTURE_CALIBRATION_MACROS_SVH
`define PIECEWISE_LINEAR_MOISTURE_CALIBRATION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PLMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/plmc_pkg.sv
package plmc_pkg;

  localparam int SAMPLE_BITS  = 10;
  localparam int Q_BITS       = 12;
  localparam int PROD_BITS    = SAMPLE_BITS + Q_BITS;
  localparam int OUT_BITS     = 14;
  localparam int NUM_POINTS   = 5;
  localparam int CFG_IDX_BITS = 3;
  localparam int PIPE_DEPTH   = Q_BITS + 3;

  localparam logic [Q_BITS-1:0]   SEG_SPAN   = Q_BITS'(2500);
  localparam logic [OUT_BITS-1:0] FULL_SCALE = OUT_BITS'(10000);

  localparam logic [CFG_IDX_BITS-1:0] REG_DRY     = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_QUARTER = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF    = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_THREE_Q = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] REG_WET     = CFG_IDX_BITS'(4);

  localparam logic [SAMPLE_BITS-1:0] DRY_RESET     = SAMPLE_BITS'(461);
  localparam logic [SAMPLE_BITS-1:0] QUARTER_RESET = SAMPLE_BITS'(436);
  localparam logic [SAMPLE_BITS-1:0] HALF_RESET    = SAMPLE_BITS'(404);
  localparam logic [SAMPLE_BITS-1:0] THREE_Q_RESET = SAMPLE_BITS'(318);
  localparam logic [SAMPLE_BITS-1:0] WET_RESET     = SAMPLE_BITS'(231);

  typedef logic [NUM_POINTS-1:0][SAMPLE_BITS-1:0] points_t;

  typedef struct packed {
    logic                   valid;
    logic                   bad;
    logic [SAMPLE_BITS-1:0] num;
    logic [SAMPLE_BITS-1:0] den;
    logic [OUT_BITS-1:0]    base;
  } front_t;

  typedef struct packed {
    logic                   valid;
    logic                   bad;
    logic [SAMPLE_BITS-1:0] rem;
    logic [SAMPLE_BITS-1:0] den;
    logic [Q_BITS-1:0]      lo;
    logic [Q_BITS-1:0]      q;
    logic [OUT_BITS-1:0]    base;
  } pipe_t;

  function automatic logic [OUT_BITS-1:0] seg_base(input logic [1:0] seg);
    logic [OUT_BITS-1:0] b;
    case (seg)
      2'd0:    b = OUT_BITS'(0);
      2'd1:    b = OUT_BITS'(2500);
      2'd2:    b = OUT_BITS'(5000);
      2'd3:    b = OUT_BITS'(7500);
      default: b = OUT_BITS'(0);
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/plmc_front.sv
module plmc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic [plmc_pkg::SAMPLE_BITS-1:0] sample,
  input  plmc_pkg::points_t               pts,
  output plmc_pkg::front_t                out_word
);
  import plmc_pkg::*;

  logic                   bad;
  logic                   gt1, gt2, gt3;
  logic [1:0]             seg;
  logic [SAMPLE_BITS-1:0] upper, lower;
  front_t                 word_next;

  always_comb begin
    bad = !((pts[0] > pts[1]) && (pts[1] > pts[2]) &&
            (pts[2] > pts[3]) && (pts[3] > pts[4]));
    gt1 = sample > pts[1];
    gt2 = sample > pts[2];
    gt3 = sample > pts[3];
    if (gt1)      seg = 2'd0;
    else if (gt2) seg = 2'd1;
    else if (gt3) seg = 2'd2;
    else          seg = 2'd3;
    case (seg)
      2'd0:    begin upper = pts[0]; lower = pts[1]; end
      2'd1:    begin upper = pts[1]; lower = pts[2]; end
      2'd2:    begin upper = pts[2]; lower = pts[3]; end
      2'd3:    begin upper = pts[3]; lower = pts[4]; end
      default: begin upper = pts[0]; lower = pts[1]; end
    endcase

    word_next.valid = take;
    word_next.bad   = bad;
    word_next.num   = '0;
    word_next.den   = SAMPLE_BITS'(1);
    word_next.base  = '0;
    if (bad || (sample >= pts[0])) begin
      word_next.base = '0;
    end else if (sample <= pts[4]) begin
      word_next.base = FULL_SCALE;
    end else begin
      word_next.num  = upper - sample;
      word_next.den  = upper - lower;
      word_next.base = seg_base(seg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_word.valid <= 1'b0;
    end else begin
      out_word.valid <= word_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_word.bad  <= word_next.bad;
    out_word.num  <= word_next.num;
    out_word.den  <= word_next.den;
    out_word.base <= word_next.base;
  end

endmodule

// File: hw/rtl/plmc_scale.sv
module plmc_scale (
  input  logic             clk,
  input  logic             rst,
  input  plmc_pkg::front_t in_word,
  output plmc_pkg::pipe_t  out_word
);
  import plmc_pkg::*;

  logic [PROD_BITS-1:0] prod;

  assign prod = PROD_BITS'(in_word.num) * PROD_BITS'(SEG_SPAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_word.valid <= 1'b0;
    end else begin
      out_word.valid <= in_word.valid;
    end
  end

  // top bits are already below den since num < den
  always_ff @(posedge clk) begin
    out_word.bad  <= in_word.bad;
    out_word.rem  <= prod[PROD_BITS-1:Q_BITS];
    out_word.lo   <= prod[Q_BITS-1:0];
    out_word.den  <= in_word.den;
    out_word.q    <= '0;
    out_word.base <= in_word.base;
  end

endmodule

// File: hw/rtl/plmc_div_stage.sv
module plmc_div_stage (
  input  logic            clk,
  input  logic            rst,
  input  plmc_pkg::pipe_t in_word,
  output plmc_pkg::pipe_t out_word
);
  import plmc_pkg::*;

  logic [SAMPLE_BITS:0]   trial;
  logic [SAMPLE_BITS+1:0] diff;
  logic                   borrow;

  assign trial  = {in_word.rem, in_word.lo[Q_BITS-1]};
  assign diff   = {1'b0, trial} - {2'b00, in_word.den};
  assign borrow = diff[SAMPLE_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_word.valid <= 1'b0;
    end else begin
      out_word.valid <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_word.bad  <= in_word.bad;
    out_word.den  <= in_word.den;
    out_word.base <= in_word.base;
    out_word.lo   <= {in_word.lo[Q_BITS-2:0], 1'b0};
    out_word.q    <= {in_word.q[Q_BITS-2:0], ~borrow};
    out_word.rem  <= borrow ? trial[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
  end

endmodule

// File: hw/rtl/piecewise_linear_moisture_calibration.sv
// Pipeline from the start edge to the done strobe: 1 select stage, 1 scale
// multiply, 12 restoring divide stages, 1 output add.
// Throughput: one sample per cycle; busy stays low, results cannot be stalled.
// Reset: synchronous, clears all pipeline valid bits and loads the default
// breakpoints 461, 436, 404, 318, 231.
module piecewise_linear_moisture_calibration (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [plmc_pkg::SAMPLE_BITS-1:0]    raw_sample,
  output logic                                done,
  output logic [plmc_pkg::OUT_BITS-1:0]       moisture_hundredths,
  output logic                                calib_bad,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [plmc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [plmc_pkg::SAMPLE_BITS-1:0]    cfg_data
);
  import plmc_pkg::*;

  `include "piecewise_linear_moisture_calibration_macros.svh"

  points_t pts;
  front_t  front_word;
  pipe_t   div_pipe [0:Q_BITS];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pts[0] <= DRY_RESET;
      pts[1] <= QUARTER_RESET;
      pts[2] <= HALF_RESET;
      pts[3] <= THREE_Q_RESET;
      pts[4] <= WET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DRY:     pts[0] <= cfg_data;
        REG_QUARTER: pts[1] <= cfg_data;
        REG_HALF:    pts[2] <= cfg_data;
        REG_THREE_Q: pts[3] <= cfg_data;
        REG_WET:     pts[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  plmc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (start && !busy),
    .sample   (raw_sample),
    .pts      (pts),
    .out_word (front_word)
  );

  plmc_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_word  (front_word),
    .out_word (div_pipe[0])
  );

  for (genvar i = 0; i < Q_BITS; i++) begin : g_div
    plmc_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_word  (div_pipe[i]),
      .out_word (div_pipe[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_pipe[Q_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    moisture_hundredths <= div_pipe[Q_BITS].base + OUT_BITS'(div_pipe[Q_BITS].q);
    calib_bad           <= div_pipe[Q_BITS].bad;
  end

  `PLMC_ASSERT_NOW(a_range, done, moisture_hundredths <= FULL_SCALE, "result above full scale")
  `PLMC_ASSERT_NOW(a_bad_zero, done && calib_bad, moisture_hundredths == '0, "bad calib not zero")
  `PLMC_ASSERT_NOW(a_latency, done, $past(start && !busy, PIPE_DEPTH), "done without a start")
  `PLMC_ASSERT_NEXT(a_flow, div_pipe[Q_BITS].valid, done, "finished word dropped")

endmodule

// File: verif/tb_piecewise_linear_moisture_calibration.sv
module tb_piecewise_linear_moisture_calibration;
  timeunit 1ns;
  timeprecision 1ps;

  import plmc_pkg::*;

  localparam int LATENCY = 15;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_UNUSED = REG_WET + 1'b1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LAST_UNUSED = '1;

  typedef struct packed {
    logic [OUT_BITS-1:0] moisture;
    logic                bad;
  } reading_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [SAMPLE_BITS-1:0]  raw_sample;
  logic                    done;
  logic [OUT_BITS-1:0]     moisture_hundredths;
  logic                    calib_bad;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [SAMPLE_BITS-1:0]  cfg_data;

  logic [SAMPLE_BITS-1:0] cal_points [NUM_POINTS];
  reading_t               expected_readings [$];
  int                     errors = 0;
  int                     stalled_cycles = 0;
  bit                     gaps_on = 1'b1;

  piecewise_linear_moisture_calibration uut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .raw_sample          (raw_sample),
    .done                (done),
    .moisture_hundredths (moisture_hundredths),
    .calib_bad           (calib_bad),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [OUT_BITS-1:0] predict_moisture(input logic [SAMPLE_BITS-1:0] x,
                                                           output logic bad);
    int k;
    int part;
    bad = 1'b0;
    for (k = 0; k < NUM_POINTS - 1; k++) begin
      if (cal_points[k] <= cal_points[k+1]) bad = 1'b1;
    end
    if (bad) return '0;
    if (x >= cal_points[0]) return '0;
    if (x <= cal_points[NUM_POINTS-1]) return FULL_SCALE;
    k = 0;
    while (k < NUM_POINTS - 2 && x <= cal_points[k+1]) k++;
    part = (int'(SEG_SPAN) * (int'(cal_points[k]) - int'(x))) /
           (int'(cal_points[k]) - int'(cal_points[k+1]));
    return OUT_BITS'(int'(SEG_SPAN) * k + part);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int lo;
    int hi;
    int v;
    lo = int'(cal_points[NUM_POINTS-1]) - 2;
    hi = int'(cal_points[0]) + 2;
    if (lo < 0) lo = 0;
    if (hi > 1023) hi = 1023;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 1023);
      1: begin
        v = int'(cal_points[$urandom_range(0, NUM_POINTS - 1)]);
        v = v + int'($urandom_range(0, 2)) - 1;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
      end
      default: begin
        if (lo > hi) v = $urandom_range(0, 1023);
        else v = $urandom_range(lo, hi);
      end
    endcase
    return SAMPLE_BITS'(v);
  endfunction

  task automatic idle_gap(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] x);
    reading_t r;
    logic     b;
    start <= 1'b1;
    raw_sample <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    r.moisture = predict_moisture(x, b);
    r.bad = b;
    expected_readings.push_back(r);
    if (gaps_on && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 11));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // caller lowers cfg_valid after the last word
  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [SAMPLE_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_WET) cal_points[idx] = data;
  endtask

  task automatic program_points(input int d, input int q, input int h, input int t,
                                input int w);
    cfg_write(REG_DRY, SAMPLE_BITS'(d));
    cfg_write(REG_QUARTER, SAMPLE_BITS'(q));
    cfg_write(REG_HALF, SAMPLE_BITS'(h));
    cfg_write(REG_THREE_Q, SAMPLE_BITS'(t));
    cfg_write(REG_WET, SAMPLE_BITS'(w));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic randomize_points();
    int pv [NUM_POINTS];
    int spread;
    int room;
    int j;
    spread = ($urandom_range(0, 2) == 0) ? 6 : 300;
    pv[NUM_POINTS-1] = $urandom_range(0, 1023 - (NUM_POINTS - 1));
    for (int k = NUM_POINTS - 2; k >= 0; k--) begin
      room = 1023 - pv[k+1] - k;
      pv[k] = pv[k+1] + int'($urandom_range(1, (room < spread) ? room : spread));
    end
    case ($urandom_range(0, 7))
      0: begin
        for (int k = 0; k < NUM_POINTS; k++) pv[k] = $urandom_range(0, 1023);
      end
      1: begin
        j = $urandom_range(0, NUM_POINTS - 2);
        pv[j] = pv[j+1];
      end
      default: ;
    endcase
    program_points(pv[0], pv[1], pv[2], pv[3], pv[4]);
    case ($urandom_range(0, 3))
      0: begin
        cfg_write(CFG_IDX_BITS'($urandom_range(REG_DRY, REG_WET)), SAMPLE_BITS'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      1: begin
        cfg_write(CFG_IDX_BITS'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                  SAMPLE_BITS'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      default: ;
    endcase
  endtask

  task automatic test_default_boundaries();
    send_sample('0);
    send_sample('1);
    send_sample(DRY_RESET);
    send_sample(DRY_RESET + 1'b1);
    send_sample(DRY_RESET - 1'b1);
    send_sample(QUARTER_RESET);
    send_sample(QUARTER_RESET - 1'b1);
    send_sample(HALF_RESET);
    send_sample(THREE_Q_RESET);
    send_sample(WET_RESET);
    send_sample(WET_RESET + 1'b1);
    send_sample(WET_RESET - 1'b1);
    drain();
  endtask

  task automatic test_extreme_points();
    program_points(1023, 1022, 1021, 1020, 1019);
    send_sample(10'd1023);
    send_sample(10'd1021);
    send_sample(10'd1019);
    drain();
    program_points(4, 3, 2, 1, 0);
    send_sample(10'd0);
    send_sample(10'd3);
    send_sample(10'd5);
    drain();
    program_points(1023, 767, 511, 255, 0);
    send_sample(10'd383);
    send_sample(10'd1000);
    drain();
  endtask

  task automatic test_bad_calibration();
    program_points(461, 461, 404, 318, 231);
    send_sample(10'd500);
    send_sample(10'd300);
    drain();
    program_points(0, 256, 512, 768, 1023);
    send_sample(10'd0);
    send_sample(10'd1023);
    drain();
  endtask

  task automatic test_unused_index();
    program_points(DRY_RESET, QUARTER_RESET, HALF_RESET, THREE_Q_RESET, WET_RESET);
    cfg_write(REG_FIRST_UNUSED, '1);
    cfg_write(REG_LAST_UNUSED, '0);
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_sample(QUARTER_RESET + 2'd3);
    drain();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 12; phase++) begin
      randomize_points();
      gaps_on = (phase % 3 != 2);
      repeat (40) send_sample(pick_sample());
      drain();
    end
  endtask

  task automatic test_final_burst();
    randomize_points();
    gaps_on = 1'b0;
    repeat (70) send_sample(pick_sample());
    drain();
  endtask

  always @(posedge clk) begin
    reading_t e;
    if (!rst) begin
      if (done || (start && !busy) || (cfg_valid && cfg_ready)) stalled_cycles <= 0;
      else stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
      if (done) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected word, expected none, got moisture %0d bad %0b",
                   $time, moisture_hundredths, calib_bad);
          errors++;
        end else begin
          e = expected_readings.pop_front();
          if (moisture_hundredths !== e.moisture) begin
            $display("%0t: moisture_hundredths expected %0d, got %0d",
                     $time, e.moisture, moisture_hundredths);
            errors++;
          end
          if (calib_bad !== e.bad) begin
            $display("%0t: calib_bad expected %0b, got %0b", $time, e.bad, calib_bad);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    raw_sample <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_DRY;
    cfg_data <= '0;
    cal_points[0] = DRY_RESET;
    cal_points[1] = QUARTER_RESET;
    cal_points[2] = HALF_RESET;
    cal_points[3] = THREE_Q_RESET;
    cal_points[4] = WET_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_boundaries();
    test_extreme_points();
    test_bad_calibration();
    test_unused_index();
    test_random_phases();
    test_final_burst();
    drain();
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
